@@ rtl/mam_pkg.sv @@
// Shared types, code point constants and lookup tables for the math
// alphanumeric mapper. No dependencies.

package mam_pkg;

   localparam int CpWidth  = 21;
   localparam int VarWidth = 5;

   // mathvariant codes
   localparam logic [VarWidth-1:0] VarNormal     = 5'd1;
   localparam logic [VarWidth-1:0] VarBold       = 5'd2;
   localparam logic [VarWidth-1:0] VarItalic     = 5'd3;
   localparam logic [VarWidth-1:0] VarBoldItalic = 5'd4;
   localparam logic [VarWidth-1:0] VarDouble     = 5'd8;
   localparam logic [VarWidth-1:0] VarSans       = 5'd10;
   localparam logic [VarWidth-1:0] VarBoldSans   = 5'd11;
   localparam logic [VarWidth-1:0] VarSansBoldIt = 5'd13;
   localparam logic [VarWidth-1:0] VarMono       = 5'd14;
   localparam logic [VarWidth-1:0] VarInitial    = 5'd15;
   localparam logic [VarWidth-1:0] VarTailed     = 5'd16;
   localparam logic [VarWidth-1:0] VarLooped     = 5'd17;
   localparam logic [VarWidth-1:0] VarStretched  = 5'd18;

   localparam logic [CpWidth-1:0] LatinStart   = 21'h1D400;
   localparam logic [CpWidth-1:0] LatinStep    = 21'h1D434 - 21'h1D400;
   localparam logic [CpWidth-1:0] LatinLowOff  = 21'h1D41A - 21'h1D400;
   localparam logic [CpWidth-1:0] GreekStart   = 21'h1D6A8;
   localparam logic [CpWidth-1:0] GreekStep    = 21'h1D6E2 - 21'h1D6A8;
   localparam logic [CpWidth-1:0] GreekLowOff  = 21'h1D6C2 - 21'h1D6A8;
   localparam logic [CpWidth-1:0] DigitStart   = 21'h1D7CE;
   localparam logic [CpWidth-1:0] DigitStep    = 21'h1D7D8 - 21'h1D7CE;
   localparam logic [CpWidth-1:0] ArabicLow    = 21'h00600;
   localparam logic [CpWidth-1:0] ArabicHigh   = 21'h006FF;
   localparam logic [CpWidth-1:0] ArabicOut    = 21'h1EE00;
   localparam logic [CpWidth-1:0] GreekHole    = 21'h003A2;
   localparam logic [CpWidth-1:0] Digamma      = 21'h003DC;
   localparam logic [CpWidth-1:0] DigammaSmall = 21'h003DD;
   localparam logic [CpWidth-1:0] DigammaOut   = 21'h1D7CA;
   localparam logic [CpWidth-1:0] DotlessI     = 21'h00131;
   localparam logic [CpWidth-1:0] DotlessJ     = 21'h00237;
   localparam logic [CpWidth-1:0] DotlessOut   = 21'h1D6A4;

   typedef struct packed {
      logic                 hit;
      logic [CpWidth-1:0]   point;
   } map_res_type;

   // Replace a Latin result that lands on a hole by its letterlike symbol.
   function automatic logic [CpWidth-1:0] latin_hole_fix(input logic [CpWidth-1:0] cand);
      logic [CpWidth-1:0] r;
      case (cand)
         21'h1D455: r = 21'h210E;
         21'h1D49D: r = 21'h212C;
         21'h1D4A0: r = 21'h2130;
         21'h1D4A1: r = 21'h2131;
         21'h1D4A3: r = 21'h210B;
         21'h1D4A4: r = 21'h2110;
         21'h1D4A7: r = 21'h2112;
         21'h1D4A8: r = 21'h2133;
         21'h1D4AD: r = 21'h211B;
         21'h1D4BA: r = 21'h212F;
         21'h1D4BC: r = 21'h210A;
         21'h1D4C4: r = 21'h2134;
         21'h1D506: r = 21'h212D;
         21'h1D50B: r = 21'h210C;
         21'h1D50C: r = 21'h2111;
         21'h1D515: r = 21'h211C;
         21'h1D51D: r = 21'h2128;
         21'h1D53A: r = 21'h2102;
         21'h1D53F: r = 21'h210D;
         21'h1D545: r = 21'h2115;
         21'h1D547: r = 21'h2119;
         21'h1D548: r = 21'h211A;
         21'h1D549: r = 21'h211D;
         21'h1D551: r = 21'h2124;
         default:   r = cand;
      endcase
      return r;
   endfunction

   // Arabic tables: key is the low byte of 0x06xx, result {hit, low byte of 0x1EExx}.
   function automatic logic [8:0] ar_initial_lookup(input logic [7:0] k);
      logic [8:0] r;
      case (k)
         8'h28: r = {1'b1, 8'h21};
         8'h2A: r = {1'b1, 8'h35};
         8'h2B: r = {1'b1, 8'h36};
         8'h2C: r = {1'b1, 8'h22};
         8'h2D: r = {1'b1, 8'h27};
         8'h2E: r = {1'b1, 8'h37};
         8'h33: r = {1'b1, 8'h2E};
         8'h34: r = {1'b1, 8'h34};
         8'h35: r = {1'b1, 8'h31};
         8'h36: r = {1'b1, 8'h39};
         8'h39: r = {1'b1, 8'h2F};
         8'h3A: r = {1'b1, 8'h3B};
         8'h41: r = {1'b1, 8'h30};
         8'h42: r = {1'b1, 8'h32};
         8'h43: r = {1'b1, 8'h2A};
         8'h44: r = {1'b1, 8'h2B};
         8'h45: r = {1'b1, 8'h2C};
         8'h46: r = {1'b1, 8'h2D};
         8'h47: r = {1'b1, 8'h24};
         8'h4A: r = {1'b1, 8'h29};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] ar_tailed_lookup(input logic [7:0] k);
      logic [8:0] r;
      case (k)
         8'h2C: r = {1'b1, 8'h42};
         8'h2D: r = {1'b1, 8'h47};
         8'h2E: r = {1'b1, 8'h57};
         8'h33: r = {1'b1, 8'h4E};
         8'h34: r = {1'b1, 8'h54};
         8'h35: r = {1'b1, 8'h51};
         8'h36: r = {1'b1, 8'h59};
         8'h39: r = {1'b1, 8'h4F};
         8'h3A: r = {1'b1, 8'h5B};
         8'h42: r = {1'b1, 8'h52};
         8'h44: r = {1'b1, 8'h4B};
         8'h46: r = {1'b1, 8'h4D};
         8'h4A: r = {1'b1, 8'h49};
         8'h6F: r = {1'b1, 8'h5F};
         8'hBA: r = {1'b1, 8'h5D};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] ar_stretched_lookup(input logic [7:0] k);
      logic [8:0] r;
      case (k)
         8'h28: r = {1'b1, 8'h61};
         8'h2A: r = {1'b1, 8'h75};
         8'h2B: r = {1'b1, 8'h76};
         8'h2C: r = {1'b1, 8'h62};
         8'h2D: r = {1'b1, 8'h67};
         8'h2E: r = {1'b1, 8'h77};
         8'h33: r = {1'b1, 8'h6E};
         8'h34: r = {1'b1, 8'h74};
         8'h35: r = {1'b1, 8'h71};
         8'h36: r = {1'b1, 8'h79};
         8'h37: r = {1'b1, 8'h68};
         8'h38: r = {1'b1, 8'h7A};
         8'h39: r = {1'b1, 8'h6F};
         8'h3A: r = {1'b1, 8'h7B};
         8'h41: r = {1'b1, 8'h70};
         8'h42: r = {1'b1, 8'h72};
         8'h43: r = {1'b1, 8'h6A};
         8'h45: r = {1'b1, 8'h6C};
         8'h46: r = {1'b1, 8'h6D};
         8'h47: r = {1'b1, 8'h64};
         8'h4A: r = {1'b1, 8'h69};
         8'h6E: r = {1'b1, 8'h7C};
         8'hA1: r = {1'b1, 8'h7E};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] ar_looped_lookup(input logic [7:0] k);
      logic [8:0] r;
      case (k)
         8'h27: r = {1'b1, 8'h80};
         8'h28: r = {1'b1, 8'h81};
         8'h2A: r = {1'b1, 8'h95};
         8'h2B: r = {1'b1, 8'h96};
         8'h2C: r = {1'b1, 8'h82};
         8'h2D: r = {1'b1, 8'h87};
         8'h2E: r = {1'b1, 8'h97};
         8'h2F: r = {1'b1, 8'h83};
         8'h30: r = {1'b1, 8'h98};
         8'h31: r = {1'b1, 8'h93};
         8'h32: r = {1'b1, 8'h86};
         8'h33: r = {1'b1, 8'h8E};
         8'h34: r = {1'b1, 8'h94};
         8'h35: r = {1'b1, 8'h91};
         8'h36: r = {1'b1, 8'h99};
         8'h37: r = {1'b1, 8'h88};
         8'h38: r = {1'b1, 8'h9A};
         8'h39: r = {1'b1, 8'h8F};
         8'h3A: r = {1'b1, 8'h9B};
         8'h41: r = {1'b1, 8'h90};
         8'h42: r = {1'b1, 8'h92};
         8'h44: r = {1'b1, 8'h8B};
         8'h45: r = {1'b1, 8'h8C};
         8'h46: r = {1'b1, 8'h8D};
         8'h47: r = {1'b1, 8'h84};
         8'h48: r = {1'b1, 8'h85};
         8'h4A: r = {1'b1, 8'h89};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] ar_double_lookup(input logic [7:0] k);
      logic [8:0] r;
      case (k)
         8'h28: r = {1'b1, 8'hA1};
         8'h2A: r = {1'b1, 8'hB5};
         8'h2B: r = {1'b1, 8'hB6};
         8'h2C: r = {1'b1, 8'hA2};
         8'h2D: r = {1'b1, 8'hA7};
         8'h2E: r = {1'b1, 8'hB7};
         8'h2F: r = {1'b1, 8'hA3};
         8'h30: r = {1'b1, 8'hB8};
         8'h31: r = {1'b1, 8'hB3};
         8'h32: r = {1'b1, 8'hA6};
         8'h33: r = {1'b1, 8'hAE};
         8'h34: r = {1'b1, 8'hB4};
         8'h35: r = {1'b1, 8'hB1};
         8'h36: r = {1'b1, 8'hB9};
         8'h37: r = {1'b1, 8'hA8};
         8'h38: r = {1'b1, 8'hBA};
         8'h39: r = {1'b1, 8'hAF};
         8'h3A: r = {1'b1, 8'hBB};
         8'h41: r = {1'b1, 8'hB0};
         8'h42: r = {1'b1, 8'hB2};
         8'h44: r = {1'b1, 8'hAB};
         8'h45: r = {1'b1, 8'hAC};
         8'h46: r = {1'b1, 8'hAD};
         8'h48: r = {1'b1, 8'hA5};
         8'h4A: r = {1'b1, 8'hA9};
         default: r = 9'h000;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/mam_offset_map.sv @@
// Offset arithmetic for Latin letters, digits and Greek, plus the digamma,
// dotless i/j and Latin hole cases. Depends on mam_pkg.

module mam_offset_map
   import mam_pkg::*;
(
   input  logic [CpWidth-1:0]  code_point,
   input  logic [VarWidth-1:0] variant,
   output map_res_type         result
);

   logic               var_ok;
   logic               is_upper;
   logic               is_lower;
   logic               is_digit;
   logic [5:0]         latin_base;
   logic [3:0]         latin_mult;
   logic [CpWidth-1:0] latin_cand;
   logic               digit_ok;
   logic [2:0]         digit_mult;
   logic               greek_in;
   logic [5:0]         greek_base;
   logic               greek_ok;
   logic [2:0]         greek_mult;

   always_comb begin
      var_ok   = (variant >= VarBold) && (variant <= VarStretched);
      is_upper = (code_point >= 21'h41) && (code_point <= 21'h5A);
      is_lower = (code_point >= 21'h61) && (code_point <= 21'h7A);
      is_digit = (code_point >= 21'h30) && (code_point <= 21'h39);

      latin_base = is_upper ? 6'(code_point - 21'h41)
                            : 6'(code_point - 21'h61 + LatinLowOff);
      latin_mult = 4'(variant - VarBold);
      latin_cand = LatinStart + 21'(latin_base) + 21'(latin_mult) * LatinStep;

      digit_ok   = 1'b1;
      digit_mult = 3'd0;
      case (variant)
         VarBold:     digit_mult = 3'd0;
         VarDouble:   digit_mult = 3'd1;
         VarSans:     digit_mult = 3'd2;
         VarBoldSans: digit_mult = 3'd3;
         VarMono:     digit_mult = 3'd4;
         default:     digit_ok   = 1'b0;
      endcase

      greek_in   = 1'b1;
      greek_base = 6'd0;
      if ((code_point >= 21'h391) && (code_point <= 21'h3A9)) begin
         greek_base = 6'(code_point - 21'h391);
      end else if ((code_point >= 21'h3B1) && (code_point <= 21'h3C9)) begin
         greek_base = 6'(code_point - 21'h3B1 + GreekLowOff);
      end else begin
         case (code_point)
            21'h003F4: greek_base = 6'd17;
            21'h02207: greek_base = 6'd25;
            21'h02202: greek_base = 6'd51;
            21'h003F5: greek_base = 6'd52;
            21'h003D1: greek_base = 6'd53;
            21'h003F0: greek_base = 6'd54;
            21'h003D5: greek_base = 6'd55;
            21'h003F1: greek_base = 6'd56;
            21'h003D6: greek_base = 6'd57;
            default:   greek_in   = 1'b0;
         endcase
      end

      greek_ok   = 1'b1;
      greek_mult = 3'd0;
      case (variant)
         VarBold:       greek_mult = 3'd0;
         VarItalic:     greek_mult = 3'd1;
         VarBoldItalic: greek_mult = 3'd2;
         VarBoldSans:   greek_mult = 3'd3;
         VarSansBoldIt: greek_mult = 3'd4;
         default:       greek_ok   = 1'b0;
      endcase

      result = '0;
      if (!var_ok || code_point == GreekHole) begin
         result.hit = 1'b0;
      end else if (code_point == Digamma || code_point == DigammaSmall) begin
         result.hit   = (variant == VarBold);
         result.point = DigammaOut + 21'(code_point[0]);
      end else if (code_point == DotlessI || code_point == DotlessJ) begin
         result.hit   = (variant == VarItalic);
         result.point = DotlessOut + 21'(code_point == DotlessJ);
      end else if (is_upper || is_lower) begin
         result.hit   = (variant <= VarMono);
         result.point = latin_hole_fix(latin_cand);
      end else if (is_digit) begin
         result.hit   = digit_ok;
         result.point = DigitStart + (code_point - 21'h30) + 21'(digit_mult) * DigitStep;
      end else if (greek_in) begin
         result.hit   = greek_ok;
         result.point = GreekStart + 21'(greek_base) + 21'(greek_mult) * GreekStep;
      end
   end

endmodule

@@ rtl/mam_arabic_map.sv @@
// Arabic letter lookup for the initial, tailed, looped, stretched and
// double-struck forms. Depends on mam_pkg for the tables.

module mam_arabic_map
   import mam_pkg::*;
(
   input  logic [CpWidth-1:0]  code_point,
   input  logic [VarWidth-1:0] variant,
   output map_res_type         result
);

   logic       in_block;
   logic [8:0] entry;

   always_comb begin
      in_block = (code_point >= ArabicLow) && (code_point <= ArabicHigh);
      case (variant)
         VarInitial:   entry = ar_initial_lookup(code_point[7:0]);
         VarTailed:    entry = ar_tailed_lookup(code_point[7:0]);
         VarLooped:    entry = ar_looped_lookup(code_point[7:0]);
         VarStretched: entry = ar_stretched_lookup(code_point[7:0]);
         VarDouble:    entry = ar_double_lookup(code_point[7:0]);
         default:      entry = 9'h000;
      endcase
      result.hit   = in_block && entry[8];
      result.point = ArabicOut | 21'(entry[7:0]);
   end

endmodule

@@ rtl/math_alphanumeric_mapper_top.sv @@
// Math alphanumeric mapper: top level with input stage, mapping logic
// and result register. Depends on mam_pkg, mam_offset_map, mam_arabic_map.
//
// Usage:
//   The request channel (req_valid, req_stall, req_code_point, req_variant)
//   carries one code point and a mathvariant code per transfer. The response
//   channel (rsp_valid, rsp_stall, rsp_mapped_point) returns exactly one
//   mapped code point per request, in order.
//   A transfer happens at a clock edge with valid high and stall low.
//   The input register takes the request at the transfer edge, and the
//   mapping logic loads the result register when that stage can advance
//   (result register empty or rsp_stall low), which raises rsp_valid.
//   Throughput is one item per cycle while rsp_stall is low; the input
//   and result registers advance independently, so a new request is
//   taken while a result waits, as long as one of the two stages is free.
//   When rsp_stall is held, the result holds, the input stage fills, and
//   req_stall rises once both stages are occupied.
//   Synchronous active-high reset empties both stages; no request is
//   lost or duplicated across a stall.

module math_alphanumeric_mapper_top
   import mam_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CpWidth-1:0]  req_code_point,
   input  logic [VarWidth-1:0] req_variant,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CpWidth-1:0]  rsp_mapped_point
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [CpWidth-1:0]  code_ff;
   logic [VarWidth-1:0] variant_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CpWidth-1:0]  rsp_point_ff;
   logic [CpWidth-1:0]  rsp_point_in;
   logic                advance_out;
   logic                load_s1;
   map_res_type         offset_res;
   map_res_type         arabic_res;

   mam_offset_map u_offset (
      .code_point (code_ff),
      .variant    (variant_ff),
      .result     (offset_res)
   );

   mam_arabic_map u_arabic (
      .code_point (code_ff),
      .variant    (variant_ff),
      .result     (arabic_res)
   );

   always_comb begin
      advance_out = !rsp_valid_ff || !rsp_stall;
      req_stall   = s1_valid_ff && !advance_out;
      load_s1     = req_valid && !req_stall;

      if (load_s1) begin
         s1_valid_in = 1'b1;
      end else if (advance_out) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = advance_out ? s1_valid_ff : rsp_valid_ff;

      if (offset_res.hit) begin
         rsp_point_in = offset_res.point;
      end else if (arabic_res.hit) begin
         rsp_point_in = arabic_res.point;
      end else begin
         rsp_point_in = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (load_s1) begin
         code_ff    <= req_code_point;
         variant_ff <= req_variant;
      end
      if (advance_out && s1_valid_ff) begin
         rsp_point_ff <= rsp_point_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_point = rsp_point_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_stall raised with a free stage");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response appeared without a staged request");

   a_passthrough_variant: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (variant_ff < VarBold || variant_ff > VarStretched))
         |-> (rsp_point_in == code_ff))
      else $error("unmapped variant changed the code point");

   a_one_source: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(offset_res.hit && arabic_res.hit))
      else $error("offset and Arabic mapping both claimed a code point");
`endif

endmodule
